@@ hw/rtl/sfd_pkg.sv @@
package sfd_pkg;

  localparam int PAYLOAD_BYTES = 1024;
  localparam int CNT_W = 16;
  localparam int IDX_W = 10;
  localparam int CRC_W = 16;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;
  localparam logic [23:0] HDR_PREFIX = 24'hDDCCBB;
  localparam logic [7:0] HDR_LAST = 8'hAA;
  localparam logic [7:0] FOOT_PAT [4] = '{8'hAA, 8'hBB, 8'hCC, 8'hDD};
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PAYLOAD_BYTES - 1);

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_CRC_ERR  = 2'd2,
    KIND_FOOT_ERR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_CRC_LO = 2'd1,
    OP_CRC_HI = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic             foot_ok;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } front_o_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic [CRC_W-1:0] crc_rx;
    logic [CRC_W-1:0] crc_cmp;
  } res_t;

  // msb-first crc-16, one byte
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/sfd_front.sv @@
module sfd_front import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc_i,
  input  logic [7:0] byte_i,
  output front_o_t   front_o
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_DATA,
    ST_CRC,
    ST_FOOT
  } state_t;

  state_t           state_r, state_nxt;
  logic [23:0]      window_r, window_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       sub_r, sub_nxt;
  logic             good_r, good_nxt;
  logic             match;

  assign match = (byte_i == FOOT_PAT[sub_r]);

  always_comb begin
    state_nxt = state_r;
    window_nxt = window_r;
    cnt_nxt = cnt_r;
    sub_nxt = sub_r;
    good_nxt = good_r;
    front_o = '0;
    front_o.cmd.data = byte_i;
    front_o.cmd.index = cnt_r[IDX_W-1:0];
    if (acc_i) begin
      unique case (state_r)
        ST_HUNT: begin
          if (window_r == HDR_PREFIX && byte_i == HDR_LAST) begin
            state_nxt = ST_DATA;
            window_nxt = '0;
            cnt_nxt = '0;
            sub_nxt = '0;
            good_nxt = 1'b1;
          end else begin
            window_nxt = {window_r[15:0], byte_i};
          end
        end
        ST_DATA: begin
          front_o.valid = 1'b1;
          front_o.cmd.op = OP_DATA;
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_CRC;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        ST_CRC: begin
          front_o.valid = 1'b1;
          if (sub_r == 2'd0) begin
            front_o.cmd.op = OP_CRC_LO;
            sub_nxt = 2'd1;
          end else begin
            front_o.cmd.op = OP_CRC_HI;
            sub_nxt = 2'd0;
            state_nxt = ST_FOOT;
          end
        end
        ST_FOOT: begin
          if (sub_r == 2'd3) begin
            front_o.valid = 1'b1;
            front_o.cmd.op = OP_END;
            front_o.cmd.foot_ok = good_r && match;
            state_nxt = ST_HUNT;
            window_nxt = '0;
            sub_nxt = '0;
            good_nxt = 1'b1;
          end else begin
            good_nxt = good_r && match;
            sub_nxt = sub_r + 1'b1;
          end
        end
        default: state_nxt = ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      window_r <= '0;
      cnt_r <= '0;
      sub_r <= '0;
      good_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      window_r <= window_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
      good_r <= good_nxt;
    end
  end

  // a command leaves only for a byte that was taken
  a_cmd_needs_acc: assert property (@(posedge clk) disable iff (!rst_n)
    front_o.valid |-> acc_i) else $error("front command without a beat");

  // the payload index stays below the payload length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_IDX) else $error("payload counter out of range");

endmodule

@@ hw/rtl/sfd_cmdq.sv @@
module sfd_cmdq import sfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign full_o = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign cmd_o = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o) else $error("command queue overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[CMDQ_AW-1:0])
    else $error("command queue pointers disagree with count");

endmodule

@@ hw/rtl/sfd_back.sv @@
module sfd_back import sfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  res_t             q_r [2];
  logic             head_r;
  logic [1:0]       cnt_r;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] rx_r, rx_nxt;
  logic             out_pop, room, res_valid;
  res_t             res;
  logic             tail;

  assign empty_o = (cnt_r == 2'd0);
  assign res_o = q_r[head_r];
  assign out_pop = pop_i && !empty_o;
  // a slot frees up in the same cycle as the consumer takes a beat
  assign room = (cnt_r != 2'd2) || out_pop;
  assign cmd_pop_o = room && !cmd_empty_i;
  assign tail = head_r ^ cnt_r[0];

  always_comb begin
    crc_nxt = crc_r;
    rx_nxt = rx_r;
    res = '0;
    res_valid = 1'b0;
    if (cmd_pop_o) begin
      unique case (cmd_i.op)
        OP_DATA: begin
          crc_nxt = crc16_byte(crc_r, cmd_i.data);
          res_valid = 1'b1;
          res.kind = KIND_DATA;
          res.data = cmd_i.data;
          res.index = cmd_i.index;
        end
        OP_CRC_LO: rx_nxt = {rx_r[CRC_W-1:8], cmd_i.data};
        OP_CRC_HI: rx_nxt = {cmd_i.data, rx_r[7:0]};
        OP_END: begin
          res_valid = 1'b1;
          if (!cmd_i.foot_ok) begin
            res.kind = KIND_FOOT_ERR;
          end else if (rx_r != crc_r) begin
            res.kind = KIND_CRC_ERR;
          end else begin
            res.kind = KIND_GOOD;
          end
          res.crc_rx = rx_r;
          res.crc_cmp = crc_r;
          crc_nxt = CRC_INIT;
          rx_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      // write lands behind whatever stays after this cycle's pop
      q_r[tail] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r <= '0;
      crc_r <= CRC_INIT;
      rx_r <= '0;
    end else begin
      if (out_pop) head_r <= ~head_r;
      cnt_r <= cnt_r + 2'(res_valid) - 2'(out_pop);
      crc_r <= crc_nxt;
      rx_r <= rx_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("result queue over capacity");

  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop_o && cmd_i.op == OP_END) |=> (crc_r == CRC_INIT && rx_r == '0))
    else $error("crc not restarted after frame end");

  a_data_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop_o && cmd_i.op == OP_DATA)
      |=> crc_r == crc16_byte($past(crc_r), $past(cmd_i.data)))
    else $error("running crc update wrong");

endmodule

@@ hw/rtl/serial_frame_deframer_crc16_core.sv @@
// Serial frame deframer with CRC-16 (poly 0x1021, init 0, XMODEM style). Bytes go in on
// push/full, one per cycle while full is low; results come out on empty/pop. Frames are
// DD CC BB AA, PAYLOAD_BYTES payload bytes, CRC low byte then high byte, then AA BB CC DD.
// Each payload byte gives one payload beat (kind 0) tagged with its index modulo 1024; the
// last footer byte gives one status beat (good, crc error, or footer error, footer checked
// first) with the received and computed CRC. Header, CRC and leading footer bytes give no
// beat. The classifier writes each command into the command queue at the accepting edge,
// and the CRC stage moves it into the two-entry result queue once that queue has room.
// The CRC stage handles one byte per cycle while the result queue has room, so the
// sustained rate is one byte per cycle; full rises only when the consumer stalls long
// enough to fill the four-entry command queue.
module serial_frame_deframer_crc16_core import sfd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              in_rx_byte,
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_data_byte,
  output logic [IDX_W-1:0]        out_byte_index,
  output logic [CRC_W-1:0]        out_crc_received,
  output logic [CRC_W-1:0]        out_crc_computed
);

  front_o_t front;
  logic     acc;
  logic     q_empty, q_pop;
  cmd_t     q_cmd;
  res_t     res;

  assign acc = push && !full;

  sfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_i   (acc),
    .byte_i  (in_rx_byte),
    .front_o (front)
  );

  sfd_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (front.valid),
    .cmd_i   (front.cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd)
  );

  sfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty_i (q_empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign out_kind = res.kind;
  assign out_data_byte = res.data;
  assign out_byte_index = res.index;
  assign out_crc_received = res.crc_rx;
  assign out_crc_computed = res.crc_cmp;

endmodule
